[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers. Define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

[rtl/core/mcbm_pkg.sv]
// ----------------------------------------------------------------------------
// mcbm_pkg
// Shared types and constants of the motor current / battery monitor.
// ----------------------------------------------------------------------------
package mcbm_pkg;

  localparam int CodeW     = 12;
  localparam int MvW       = 12;
  localparam int MaW       = 22;
  localparam int BatW      = 16;
  localparam int MpaW      = 16;
  localparam int ResW      = 20;
  localparam int MaskW     = 5;
  localparam int PhaseW    = 4;
  localparam int ProdW     = 33;

  localparam int BatteryPeriodDef = 10;

  localparam int AdcFsMv   = 3100;
  localparam int AdcFsCode = 4095;
  localparam int MaPerA    = 1000;

  // serial divider geometry
  localparam int DivRemW   = 20;
  localparam int DivNumW   = 22;
  localparam int DivCntW   = 5;
  localparam int MvSteps   = 12;
  localparam int MaSteps   = 22;
  localparam int BatSteps  = 16;

  // register indexes
  localparam logic [2:0] REG_MV_PER_AMP = 3'd0;
  localparam logic [2:0] REG_OC_LIMIT   = 3'd1;
  localparam logic [2:0] REG_DIV_TOP    = 3'd2;
  localparam logic [2:0] REG_DIV_BOTTOM = 3'd3;
  localparam logic [2:0] REG_BAT_LOW    = 3'd4;
  localparam logic [2:0] REG_CH_MASK    = 3'd5;

  // channel bits of enable / ok masks
  localparam int CH_LF  = 0;
  localparam int CH_LR  = 1;
  localparam int CH_RF  = 2;
  localparam int CH_RR  = 3;
  localparam int CH_BAT = 4;

  typedef struct packed {
    logic [MpaW-1:0]  mv_per_amp;
    logic [MaW-1:0]   oc_limit;
    logic [ResW-1:0]  r_top;
    logic [ResW-1:0]  r_bottom;
    logic [BatW-1:0]  bat_low;
    logic [MaskW-1:0] ch_en;
  } cfg_t;

  typedef struct packed {
    logic [DivRemW-1:0] rem_init;
    logic [DivNumW-1:0] num;
    logic [DivRemW-1:0] divisor;
    logic [DivCntW-1:0] steps;
  } div_req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_RUN,
    S_BAT_MUL,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_LF,
    OP_LR,
    OP_LMA,
    OP_RF,
    OP_RR,
    OP_RMA,
    OP_BMV,
    OP_BAT
  } op_t;

endpackage

[rtl/core/mcbm_regs.sv]
// ----------------------------------------------------------------------------
// mcbm_regs
// APB configuration register file.
// ----------------------------------------------------------------------------
module mcbm_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output mcbm_pkg::cfg_t     cfg
);
  import mcbm_pkg::*;

  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mv_per_amp <= '0;
      cfg.oc_limit   <= '1;
      cfg.r_top      <= '0;
      cfg.r_bottom   <= ResW'(1);
      cfg.bat_low    <= '0;
      cfg.ch_en      <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_MV_PER_AMP: cfg.mv_per_amp <= pwdata[MpaW-1:0];
        REG_OC_LIMIT:   cfg.oc_limit   <= pwdata[MaW-1:0];
        REG_DIV_TOP:    cfg.r_top      <= pwdata[ResW-1:0];
        REG_DIV_BOTTOM: cfg.r_bottom   <= pwdata[ResW-1:0];
        REG_BAT_LOW:    cfg.bat_low    <= pwdata[BatW-1:0];
        REG_CH_MASK:    cfg.ch_en      <= pwdata[MaskW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_MV_PER_AMP: prdata = 32'(cfg.mv_per_amp);
      REG_OC_LIMIT:   prdata = 32'(cfg.oc_limit);
      REG_DIV_TOP:    prdata = 32'(cfg.r_top);
      REG_DIV_BOTTOM: prdata = 32'(cfg.r_bottom);
      REG_BAT_LOW:    prdata = 32'(cfg.bat_low);
      REG_CH_MASK:    prdata = 32'(cfg.ch_en);
      default:        prdata = '0;
    endcase
  end

endmodule

[rtl/core/mcbm_div.sv]
// ----------------------------------------------------------------------------
// mcbm_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mcbm_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  mcbm_pkg::div_req_t          req,
  output logic                        busy,
  output logic                        done,
  output logic [mcbm_pkg::DivNumW-1:0] quot
);
  import mcbm_pkg::*;

  logic [DivRemW-1:0] rem;
  logic [DivNumW-1:0] sh;
  logic [DivRemW-1:0] divisor;
  logic [DivCntW-1:0] cnt;
  logic [DivRemW:0]   trial;
  logic [DivRemW:0]   diff;
  logic               fits;

  // remainder stays below divisor, so shifted trial fits one extra bit
  assign trial = {rem, sh[DivNumW-1]};
  assign fits  = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};
  assign quot  = sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DivCntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= req.rem_init;
      sh      <= req.num;
      divisor <= req.divisor;
    end else if (busy) begin
      rem <= fits ? diff[DivRemW-1:0] : trial[DivRemW-1:0];
      sh  <= {sh[DivNumW-2:0], fits};
    end
  end

endmodule

[rtl/core/motor_current_battery_monitor_core.sv]
// Work per beat: the shared divider, one quotient bit per cycle, runs six
//   divides, eight on a battery tick, seven if that tick's divide saturates
//   or its R2 is zero. A new beat is taken only after the previous result
//   has been loaded into the output register, so a result stall holds input.
// Reset: synchronous, active high; registers return to defaults, tick phase,
//   overcurrent latch and held battery values clear, output beat dropped.
// ----------------------------------------------------------------------------
// motor_current_battery_monitor_core
// Scales four current-sense codes and a battery code through one serial
// divider, flags overcurrent and battery low, streams one result per tick.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module motor_current_battery_monitor_core #(
  parameter int BATTERY_PERIOD = mcbm_pkg::BatteryPeriodDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // lf_code, lr_code, rf_code, rr_code, battery_code, read_ok_mask, pad
  input  logic [71:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // left_current_ma, right_current_ma, overcurrent, stop_request,
  // battery_updated, pack_mv, pack_low
  output logic [63:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mcbm_pkg::*;

  localparam int OutOverBit = 2 * MaW;
  localparam int OutStopBit = 2 * MaW + 1;

  cfg_t     cfg;
  div_req_t div_req;
  logic     div_start;
  logic     div_busy;
  logic     div_done;
  logic [DivNumW-1:0] div_quot;

  state_t state, state_next;
  op_t    op, op_next;

  logic [CodeW-1:0] cd_lf, cd_lr, cd_rf, cd_rr, cd_bat;
  logic [CodeW-1:0] sel_code;
  logic [MaskW-1:0] in_ok;
  logic [MaskW-1:0] ch_use;
  logic [MvW-1:0]   mv_fwd, mv_rev, mv_max, bat_mvin;
  logic [MaW-1:0]   left_ma, rt_ma;
  logic [ProdW-1:0] bat_prod;
  logic [BatW-1:0]  bat_res;
  logic             bat_tick;
  logic             bat_skip;
  logic [23:0]      mv_prod;
  logic [MaW-1:0]   ma_prod;
  logic [ResW:0]    r_sum;

  logic [PhaseW-1:0] phase;
  logic [PhaseW:0]   phase_inc;
  logic              oc_latch;
  logic [BatW-1:0]   held_mv, held_mv_next;
  logic              held_low, held_low_next;
  logic              over, stop, load_out, accept;

  mcbm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mcbm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .req   (div_req),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign in_ok  = s_tdata[64:60];
  assign ch_use = cfg.ch_en & in_ok;
  assign accept = s_tvalid && s_tready;

  // operand selection for the divider
  always_comb begin
    unique case (op)
      OP_LF:   sel_code = cd_lf;
      OP_LR:   sel_code = cd_lr;
      OP_RF:   sel_code = cd_rf;
      OP_RR:   sel_code = cd_rr;
      default: sel_code = cd_bat;
    endcase
  end

  assign mv_max   = (mv_fwd > mv_rev) ? mv_fwd : mv_rev;
  assign mv_prod  = 24'(sel_code) * 24'(AdcFsMv);
  assign ma_prod  = MaW'(mv_max) * MaW'(MaPerA);
  assign r_sum    = {1'b0, cfg.r_top} + {1'b0, cfg.r_bottom};
  assign bat_skip = (cfg.r_bottom == '0) ||
                    ({3'b000, bat_prod[ProdW-1:BatSteps]} >= cfg.r_bottom);

  always_comb begin
    unique case (op) inside
      OP_LMA, OP_RMA: begin
        div_req.rem_init = '0;
        div_req.num      = ma_prod;
        div_req.divisor  = DivRemW'(cfg.mv_per_amp);
        div_req.steps    = DivCntW'(MaSteps);
      end
      OP_BAT: begin
        div_req.rem_init = DivRemW'(bat_prod[ProdW-1:BatSteps]);
        div_req.num      = {bat_prod[BatSteps-1:0], (DivNumW-BatSteps)'(0)};
        div_req.divisor  = cfg.r_bottom;
        div_req.steps    = DivCntW'(BatSteps);
      end
      default: begin
        div_req.rem_init = DivRemW'(mv_prod[23:MvSteps]);
        div_req.num      = {mv_prod[MvSteps-1:0], (DivNumW-MvSteps)'(0)};
        div_req.divisor  = DivRemW'(AdcFsCode);
        div_req.steps    = DivCntW'(MvSteps);
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= OP_LF;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

  always_comb begin
    state_next = state;
    op_next    = op;
    s_tready   = 1'b0;
    div_start  = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = !rst;
        if (s_tvalid && !rst) begin
          state_next = S_LOAD;
          op_next    = OP_LF;
        end
      end
      S_LOAD: begin
        if (op == OP_BAT && bat_skip) begin
          state_next = S_DONE;
        end else begin
          div_start  = 1'b1;
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (div_done) begin
          unique case (op)
            OP_RMA: begin
              if (bat_tick) begin
                op_next    = OP_BMV;
                state_next = S_LOAD;
              end else begin
                state_next = S_DONE;
              end
            end
            OP_BMV: state_next = S_BAT_MUL;
            OP_BAT: state_next = S_DONE;
            default: begin
              op_next    = op_t'(op + 3'd1);
              state_next = S_LOAD;
            end
          endcase
        end
      end
      S_BAT_MUL: begin
        op_next    = OP_BAT;
        state_next = S_LOAD;
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cd_lf  <= ch_use[CH_LF]  ? s_tdata[11:0]  : '0;
      cd_lr  <= ch_use[CH_LR]  ? s_tdata[23:12] : '0;
      cd_rf  <= ch_use[CH_RF]  ? s_tdata[35:24] : '0;
      cd_rr  <= ch_use[CH_RR]  ? s_tdata[47:36] : '0;
      cd_bat <= ch_use[CH_BAT] ? s_tdata[59:48] : '0;
    end
    if (state == S_RUN && div_done) begin
      unique case (op) inside
        OP_LF, OP_RF: mv_fwd   <= div_quot[MvW-1:0];
        OP_LR, OP_RR: mv_rev   <= div_quot[MvW-1:0];
        OP_LMA:       left_ma  <= (cfg.mv_per_amp == '0) ? '0 : div_quot;
        OP_RMA:       rt_ma    <= (cfg.mv_per_amp == '0) ? '0 : div_quot;
        OP_BMV:       bat_mvin <= div_quot[MvW-1:0];
        default:      bat_res  <= div_quot[BatW-1:0];
      endcase
    end
    if (state == S_LOAD && op == OP_BAT && bat_skip) begin
      bat_res <= (cfg.r_bottom == '0) ? '0 : '1;
    end
    if (state == S_BAT_MUL) begin
      bat_prod <= ProdW'(bat_mvin) * ProdW'(r_sum);
    end
  end

  // tick state and result beat
  assign over          = (left_ma > cfg.oc_limit) || (rt_ma > cfg.oc_limit);
  assign stop          = over && !oc_latch;
  assign held_mv_next  = bat_tick ? bat_res : held_mv;
  assign held_low_next = bat_tick ? (bat_res < cfg.bat_low) : held_low;
  assign phase_inc     = {1'b0, phase} + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      bat_tick <= 1'b0;
      phase    <= '0;
      oc_latch <= 1'b0;
      held_mv  <= '0;
      held_low <= 1'b0;
    end else begin
      if (accept) begin
        bat_tick <= (phase == '0) && cfg.ch_en[CH_BAT];
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
        oc_latch <= over;
        held_mv  <= held_mv_next;
        held_low <= held_low_next;
        if (phase_inc >= (PhaseW+1)'(BATTERY_PERIOD)) begin
          phase <= '0;
        end else begin
          phase <= phase_inc[PhaseW-1:0];
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {held_low_next, held_mv_next, bat_tick, stop, over, rt_ma, left_ma};
    end
  end

  `ASSERT_IMPLY(a_idle_div_quiet, clk, rst, state == S_IDLE, !div_busy && !div_done, "divider active while idle")
  `ASSERT_IMPLY(a_done_in_run, clk, rst, div_done, state == S_RUN, "divider result outside run state")
  `ASSERT_NEXT(a_accept_blocks, clk, rst, accept, !s_tready, "second beat taken while busy")
  `ASSERT_IMPLY(a_stop_needs_over, clk, rst, m_tvalid && m_tdata[OutStopBit], m_tdata[OutOverBit], "stop without overcurrent")

endmodule
